/* src/mlfq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfq_pkg
// Shared sizes, codes and reset values of the multilevel feedback queue
// scheduler.
// ----------------------------------------------------------------------------
package mlfq_pkg;

  localparam int unsigned NUM_TASKS   = 32;
  localparam int unsigned TOP_LEVEL   = 3;
  localparam int unsigned NUM_LEVELS  = TOP_LEVEL + 1;
  localparam int unsigned TID_W       = $clog2(NUM_TASKS);
  localparam int unsigned LVL_W       = $clog2(NUM_LEVELS);
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned INTERVAL_W  = 20;
  localparam int unsigned BOOST_RESET = 2000;

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_SCHED = 1'b1;

  typedef logic [TID_W-1:0] tid_t;
  typedef logic [LVL_W-1:0] lvl_t;

endpackage

/* src/multilevel_feedback_queue_scheduler_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multilevel_feedback_queue_scheduler_top
// Per-level task FIFOs as linked lists in a link memory, task levels in a
// level memory, with periodic boost of all queued tasks to the top level.
// ----------------------------------------------------------------------------
// Channel   Ports                    Transfer
// input     start/busy, in_*         start high while busy low
// result    out_valid, out_*         one cycle strobe, cannot be stalled
// config    cfg_we, cfg_wdata        cfg_we high at a rising edge
//
// An add passes ST_ALVL and ST_PUT. A schedule passes ST_PICK, ST_TAKE and,
// if the current task is re-queued, ST_PUT; in a boost, ST_BOOST splices the
// lower lists onto the top list; the link memory port is used once per cycle.
// Synchronous reset empties all lists and re-arms the deadline to 2000.
// busy is high while an item is in work; results are never held.
// ----------------------------------------------------------------------------
module multilevel_feedback_queue_scheduler_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_command,
  input  mlfq_pkg::tid_t               in_task_id,
  input  logic                         in_set_level,
  input  mlfq_pkg::lvl_t               in_level_in,
  input  logic                         in_current_is_idle,
  input  logic                         in_current_running,
  input  logic                         in_slice_exhausted,
  input  logic [mlfq_pkg::TIME_W-1:0]  in_now_ms,
  output logic                         out_valid,
  output mlfq_pkg::tid_t               out_chosen_task,
  output logic                         out_next_is_idle,
  output logic                         out_do_switch,
  output logic                         out_reload_slice,
  output mlfq_pkg::lvl_t               out_current_level,
  output logic                         out_boosted,
  input  logic                         cfg_we,
  input  logic [mlfq_pkg::INTERVAL_W-1:0] cfg_wdata
);
  import mlfq_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ALVL  = 3'd1;
  localparam logic [2:0] ST_BOOST = 3'd2;
  localparam logic [2:0] ST_PICK  = 3'd3;
  localparam logic [2:0] ST_TAKE  = 3'd4;
  localparam logic [2:0] ST_PUT   = 3'd5;

  localparam lvl_t TOP = lvl_t'(TOP_LEVEL);

  logic [2:0] state_r, state_nxt;

  // memories
  tid_t link_mem [NUM_TASKS];
  lvl_t lvl_mem  [NUM_TASKS];
  tid_t link_rd_r;
  lvl_t lvl_rd_r;
  logic link_we;
  tid_t link_wa, link_wd, link_ra;
  logic lvl_we;
  tid_t lvl_wa, lvl_ra;
  lvl_t lvl_wd;

  // list heads in flops
  tid_t head_r [NUM_LEVELS];
  tid_t tail_r [NUM_LEVELS];
  tid_t head_nxt [NUM_LEVELS];
  tid_t tail_nxt [NUM_LEVELS];
  logic [NUM_LEVELS-1:0] nonempty_r, nonempty_nxt;
  logic [NUM_TASKS-1:0]  queued_r, queued_nxt;
  logic [NUM_TASKS-1:0]  topflag_r, topflag_nxt;

  logic [INTERVAL_W-1:0] interval_r;
  logic [TIME_W-1:0]     deadline_r, deadline_nxt;

  // latched item
  logic cmd_r, set_r, idle_r, run_r, exh_r;
  tid_t tid_r;
  lvl_t lin_r;

  lvl_t cnt_r, cnt_nxt;
  lvl_t pick_r, pick_nxt;
  logic any_r, any_nxt;
  lvl_t put_lvl_r, put_lvl_nxt;
  logic boosted_r, boosted_nxt;

  tid_t next_r, next_nxt;
  logic sw_r, sw_nxt, reload_r, reload_nxt;
  lvl_t cur_r, cur_nxt;

  logic emit;
  logic accept;
  lvl_t cl, nl;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    nonempty_nxt = nonempty_r;
    queued_nxt   = queued_r;
    topflag_nxt  = topflag_r;
    deadline_nxt = deadline_r;
    cnt_nxt      = cnt_r;
    pick_nxt     = pick_r;
    any_nxt      = any_r;
    put_lvl_nxt  = put_lvl_r;
    boosted_nxt  = boosted_r;
    next_nxt     = next_r;
    sw_nxt       = sw_r;
    reload_nxt   = reload_r;
    cur_nxt      = cur_r;
    emit         = 1'b0;
    link_we      = 1'b0;
    link_wa      = '0;
    link_wd      = '0;
    link_ra      = head_r[pick_nxt];
    lvl_we       = 1'b0;
    lvl_wa       = tid_r;
    lvl_wd       = '0;
    lvl_ra       = tid_r;
    cl           = '0;
    nl           = '0;

    unique case (state_r)
      ST_IDLE: begin
        lvl_ra = in_task_id;
        if (accept) begin
          boosted_nxt = 1'b0;
          if (in_command == CMD_ADD) begin
            if (in_set_level) begin
              lvl_we = 1'b1;
              lvl_wa = in_task_id;
              lvl_wd = in_level_in;
              topflag_nxt[in_task_id] = 1'b0;
            end
            state_nxt = ST_ALVL;
          end else if (in_now_ms >= deadline_r) begin
            // raise every queued task, then splice lists level by level
            topflag_nxt  = topflag_r | queued_r;
            deadline_nxt = in_now_ms + TIME_W'(interval_r);
            boosted_nxt  = 1'b1;
            cnt_nxt      = TOP - lvl_t'(1);
            state_nxt    = ST_BOOST;
          end else begin
            state_nxt = ST_PICK;
          end
        end
      end

      ST_ALVL: begin
        if (set_r)          put_lvl_nxt = lin_r;
        else if (topflag_r[tid_r]) put_lvl_nxt = TOP;
        else                put_lvl_nxt = lvl_rd_r;
        state_nxt = ST_PUT;
      end

      ST_BOOST: begin
        if (nonempty_r[cnt_r]) begin
          if (nonempty_r[TOP]) begin
            link_we = 1'b1;
            link_wa = tail_r[TOP];
            link_wd = head_r[cnt_r];
          end else begin
            head_nxt[TOP] = head_r[cnt_r];
          end
          tail_nxt[TOP]       = tail_r[cnt_r];
          nonempty_nxt[TOP]   = 1'b1;
          nonempty_nxt[cnt_r] = 1'b0;
        end
        if (cnt_r == '0) state_nxt = ST_PICK;
        else             cnt_nxt   = cnt_r - lvl_t'(1);
      end

      ST_PICK: begin
        any_nxt  = 1'b0;
        pick_nxt = '0;
        for (int i = 0; i < NUM_LEVELS; i++) begin
          if (nonempty_r[i]) begin
            any_nxt  = 1'b1;
            pick_nxt = lvl_t'(i);
          end
        end
        link_ra   = head_r[pick_nxt];
        state_nxt = ST_TAKE;
      end

      ST_TAKE: begin
        next_nxt = '0;
        if (any_r) begin
          next_nxt = head_r[pick_r];
          queued_nxt[head_r[pick_r]] = 1'b0;
          if (head_r[pick_r] == tail_r[pick_r]) nonempty_nxt[pick_r] = 1'b0;
          else                                  head_nxt[pick_r] = link_rd_r;
        end
        sw_nxt     = any_r || !idle_r;
        reload_nxt = 1'b0;
        cur_nxt    = '0;
        state_nxt  = ST_IDLE;
        if (sw_nxt && !idle_r) begin
          cl = topflag_r[tid_r] ? TOP : lvl_rd_r;
          nl = cl;
          if (cl == '0) begin
            reload_nxt = 1'b1;
          end else if (exh_r) begin
            reload_nxt = 1'b1;
            nl = cl - lvl_t'(1);
          end
          cur_nxt = nl;
          lvl_we  = 1'b1;
          lvl_wd  = nl;
          topflag_nxt[tid_r] = 1'b0;
          if (run_r) begin
            put_lvl_nxt = nl;
            state_nxt   = ST_PUT;
          end
        end
        if (state_nxt == ST_IDLE) emit = 1'b1;
      end

      ST_PUT: begin
        if (!queued_r[tid_r]) begin
          if (nonempty_r[put_lvl_r]) begin
            link_we = 1'b1;
            link_wa = tail_r[put_lvl_r];
            link_wd = tid_r;
          end else begin
            head_nxt[put_lvl_r] = tid_r;
          end
          tail_nxt[put_lvl_r]     = tid_r;
          nonempty_nxt[put_lvl_r] = 1'b1;
          queued_nxt[tid_r]       = 1'b1;
        end
        emit      = (cmd_r == CMD_SCHED);
        state_nxt = ST_IDLE;
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // memories: write then registered read
  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_wa] <= link_wd;
    link_rd_r <= link_mem[link_ra];
    if (lvl_we) lvl_mem[lvl_wa] <= lvl_wd;
    lvl_rd_r <= lvl_mem[lvl_ra];
  end

  // payload registers
  always_ff @(posedge clk) begin
    head_r    <= head_nxt;
    tail_r    <= tail_nxt;
    cnt_r     <= cnt_nxt;
    pick_r    <= pick_nxt;
    any_r     <= any_nxt;
    put_lvl_r <= put_lvl_nxt;
    boosted_r <= boosted_nxt;
    next_r    <= next_nxt;
    sw_r      <= sw_nxt;
    reload_r  <= reload_nxt;
    cur_r     <= cur_nxt;
    if (accept) begin
      cmd_r  <= in_command;
      tid_r  <= in_task_id;
      set_r  <= in_set_level;
      lin_r  <= in_level_in;
      idle_r <= in_current_is_idle;
      run_r  <= in_current_running;
      exh_r  <= in_slice_exhausted;
    end
    if (emit) begin
      out_chosen_task   <= next_nxt;
      out_next_is_idle  <= !any_r;
      out_do_switch     <= sw_nxt;
      out_reload_slice  <= reload_nxt;
      out_current_level <= cur_nxt;
      out_boosted       <= boosted_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      nonempty_r <= '0;
      queued_r   <= '0;
      topflag_r  <= '0;
      interval_r <= INTERVAL_W'(BOOST_RESET);
      deadline_r <= TIME_W'(BOOST_RESET);
      out_valid  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      nonempty_r <= nonempty_nxt;
      queued_r   <= queued_nxt;
      topflag_r  <= topflag_nxt;
      deadline_r <= deadline_nxt;
      out_valid  <= emit;
      if (cfg_we) interval_r <= cfg_wdata;
    end
  end

endmodule

/* src/mlfq_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfq_checker
// Port-level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module mlfq_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input logic                 out_valid,
  input mlfq_pkg::tid_t       out_chosen_task,
  input logic                 out_next_is_idle,
  input logic                 out_do_switch,
  input logic                 out_reload_slice,
  input mlfq_pkg::lvl_t       out_current_level
);
  import mlfq_pkg::*;

  // an accepted transfer keeps the block busy for the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accept did not raise busy");

  // a result comes out as the work finishes
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && $past(busy)) else $error("result outside work end");

  a_idle_task_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_next_is_idle |-> out_chosen_task == '0)
    else $error("idle result carries a task");

  // no switch means idle stays idle with nothing to handle
  a_no_switch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_do_switch |->
      out_next_is_idle && !out_reload_slice && out_current_level == '0)
    else $error("inconsistent no-switch result");

endmodule

bind multilevel_feedback_queue_scheduler_top mlfq_checker u_mlfq_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_chosen_task   (out_chosen_task),
  .out_next_is_idle  (out_next_is_idle),
  .out_do_switch     (out_do_switch),
  .out_reload_slice  (out_reload_slice),
  .out_current_level (out_current_level)
);

/* sim/tb_multilevel_feedback_queue_scheduler_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multilevel_feedback_queue_scheduler_top
// Drives add and schedule commands into the scheduler, mirrors its per-level
// queues, task levels and boost deadline in a scoreboard, and checks every
// schedule result field by field against the mirrored decision.
// ----------------------------------------------------------------------------
module tb_multilevel_feedback_queue_scheduler_top;
  import mlfq_pkg::*;

  localparam int unsigned STALL_LIMIT = 4000;

  typedef struct {
    logic        command;
    tid_t        task_id;
    logic        set_level;
    lvl_t        level_in;
    logic        cur_idle;
    logic        running;
    logic        exhausted;
    logic [31:0] now_ms;
  } sched_cmd_t;

  typedef struct {
    tid_t chosen_task;
    logic next_idle;
    logic do_switch;
    logic reload;
    lvl_t cur_level;
    logic boosted;
  } sched_decision_t;

  class mlfq_scoreboard;
    tid_t             head [NUM_LEVELS];
    tid_t             tail [NUM_LEVELS];
    bit               nonempty [NUM_LEVELS];
    tid_t             link [NUM_TASKS];
    lvl_t             task_lvl [NUM_TASKS];
    bit               queued [NUM_TASKS];
    logic [31:0]      deadline;
    logic [19:0]      interval;
    sched_decision_t  decisions_due [$];
    int               errors;
    int               checked;
    int               boosts;

    function void clear();
      foreach (nonempty[i]) nonempty[i] = 0;
      foreach (queued[i]) begin
        queued[i] = 0;
        task_lvl[i] = '0;
      end
      deadline = BOOST_RESET;
      interval = 20'(BOOST_RESET);
      decisions_due.delete();
      errors = 0;
      checked = 0;
      boosts = 0;
    endfunction

    function void enqueue(tid_t t);
      lvl_t lv;
      if (queued[t]) return;
      lv = task_lvl[t];
      if (nonempty[lv]) link[tail[lv]] = t;
      else head[lv] = t;
      tail[lv] = t;
      nonempty[lv] = 1;
      queued[t] = 1;
    endfunction

    function tid_t dequeue(int lv);
      tid_t t;
      t = head[lv];
      queued[t] = 0;
      if (t == tail[lv]) nonempty[lv] = 0;
      else head[lv] = link[t];
      return t;
    endfunction

    function void raise_all();
      for (int lv = TOP_LEVEL - 1; lv >= 0; lv--) begin
        if (!nonempty[lv]) continue;
        if (nonempty[TOP_LEVEL]) link[tail[TOP_LEVEL]] = head[lv];
        else head[TOP_LEVEL] = head[lv];
        tail[TOP_LEVEL] = tail[lv];
        nonempty[TOP_LEVEL] = 1;
        nonempty[lv] = 0;
      end
      foreach (queued[t]) if (queued[t]) task_lvl[t] = lvl_t'(TOP_LEVEL);
    endfunction

    function void note_transfer(sched_cmd_t c);
      sched_decision_t d;
      if (c.command == CMD_ADD) begin
        if (c.set_level) task_lvl[c.task_id] = c.level_in;
        enqueue(c.task_id);
        return;
      end
      d = '{default: '0};
      d.next_idle = 1;
      if (c.now_ms >= deadline) begin
        raise_all();
        deadline = c.now_ms + 32'(interval);
        d.boosted = 1;
        boosts++;
      end
      for (int lv = TOP_LEVEL; lv >= 0; lv--) begin
        if (nonempty[lv]) begin
          d.chosen_task = dequeue(lv);
          d.next_idle = 0;
          break;
        end
      end
      d.do_switch = !(d.next_idle && c.cur_idle);
      if (d.do_switch && !c.cur_idle) begin
        d.cur_level = task_lvl[c.task_id];
        if (d.cur_level != 0) begin
          if (c.exhausted) begin
            d.reload = 1;
            d.cur_level--;
          end
        end else begin
          d.reload = 1;
        end
        task_lvl[c.task_id] = d.cur_level;
        if (c.running) enqueue(c.task_id);
      end
      decisions_due.push_back(d);
    endfunction

    function void check_decision(sched_decision_t a);
      sched_decision_t e;
      if (decisions_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: next=%0d idle=%0b", a.chosen_task,
                                   a.next_idle);
        return;
      end
      e = decisions_due.pop_front();
      checked++;
      if (e.next_idle != a.next_idle || (!e.next_idle && e.chosen_task != a.chosen_task) ||
          e.do_switch != a.do_switch || e.reload != a.reload ||
          e.cur_level != a.cur_level || e.boosted != a.boosted) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch #%0d exp next=%0d idle=%0b sw=%0b rl=%0b lv=%0d bst=%0b",
                   checked, e.chosen_task, e.next_idle, e.do_switch, e.reload,
                   e.cur_level, e.boosted);
          $display("  act next=%0d idle=%0b sw=%0b rl=%0b lv=%0d bst=%0b",
                   a.chosen_task, a.next_idle, a.do_switch, a.reload,
                   a.cur_level, a.boosted);
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_command;
  tid_t        in_task_id;
  logic        in_set_level;
  lvl_t        in_level_in;
  logic        in_current_is_idle;
  logic        in_current_running;
  logic        in_slice_exhausted;
  logic [31:0] in_now_ms;
  logic        out_valid;
  tid_t        out_chosen_task;
  logic        out_next_is_idle;
  logic        out_do_switch;
  logic        out_reload_slice;
  lvl_t        out_current_level;
  logic        out_boosted;
  logic        cfg_we;
  logic [19:0] cfg_wdata;

  multilevel_feedback_queue_scheduler_top dut (.*);

  mlfq_scoreboard sched_sb;
  bit          level_known [NUM_TASKS];
  logic [31:0] clock_ms;
  bit          gaps_on;
  int          stall_cycles;
  int          items_sent;
  int          cfg_writes;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    sched_sb = new();
    sched_sb.clear();
  end

  // Note each accepted transfer and check each result strobe.
  always @(posedge clk) begin
    if (rst_n && start && !busy)
      sched_sb.note_transfer('{in_command, in_task_id, in_set_level, in_level_in,
                               in_current_is_idle, in_current_running,
                               in_slice_exhausted, in_now_ms});
    if (rst_n && out_valid)
      sched_sb.check_decision('{out_chosen_task, out_next_is_idle, out_do_switch,
                                out_reload_slice, out_current_level, out_boosted});
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_we) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_cmd(sched_cmd_t c);
    in_command         <= c.command;
    in_task_id         <= c.task_id;
    in_set_level       <= c.set_level;
    in_level_in        <= c.level_in;
    in_current_is_idle <= c.cur_idle;
    in_current_running <= c.running;
    in_slice_exhausted <= c.exhausted;
    in_now_ms          <= c.now_ms;
    start              <= 1'b1;
    do @(posedge clk); while (!(start && !busy));
    items_sent++;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic add_task(tid_t t, logic setl, lvl_t lv);
    send_cmd('{CMD_ADD, t, setl, lv, 1'b0, 1'b0, 1'b0, clock_ms});
    if (setl) level_known[t] = 1;
  endtask

  task automatic schedule(tid_t t, logic idle, logic run, logic exh, logic [31:0] now);
    send_cmd('{CMD_SCHED, t, 1'b0, 2'd0, idle, run, exh, now});
  endtask

  // Drain, then let an add still in work settle before the write.
  task automatic write_interval(logic [19:0] v);
    start <= 1'b0;
    @(posedge clk);
    while (sched_sb.decisions_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    while (busy) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    sched_sb.interval = v;
    cfg_we <= 1'b0;
    cfg_writes++;
  endtask

  function automatic tid_t pick_known(output bit found);
    tid_t t;
    found = 0;
    for (int k = 0; k < 64; k++) begin
      t = tid_t'($urandom_range(0, NUM_TASKS - 1));
      if (level_known[t]) begin
        found = 1;
        return t;
      end
    end
    return t;
  endfunction

  task automatic random_items(int count);
    tid_t t;
    bit   ok;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 39) == 0) clock_ms = $urandom();
      else clock_ms += $urandom_range(0, 300);
      if ($urandom_range(0, 99) < 45) begin
        t = tid_t'($urandom_range(0, NUM_TASKS - 1));
        add_task(t, level_known[t] ? logic'($urandom_range(0, 1)) : 1'b1,
                 lvl_t'($urandom_range(0, TOP_LEVEL)));
      end else begin
        t = pick_known(ok);
        if (!ok || $urandom_range(0, 4) == 0)
          schedule(tid_t'($urandom_range(0, NUM_TASKS - 1)), 1'b1,
                   logic'($urandom_range(0, 1)), logic'($urandom_range(0, 1)), clock_ms);
        else
          schedule(t, 1'b0, logic'($urandom_range(0, 3) != 0),
                   logic'($urandom_range(0, 1)), clock_ms);
      end
    end
  endtask

  initial begin
    rst_n              <= 1'b0;
    start              <= 1'b0;
    in_command         <= CMD_ADD;
    in_task_id         <= '0;
    in_set_level       <= 1'b0;
    in_level_in        <= '0;
    in_current_is_idle <= 1'b0;
    in_current_running <= 1'b0;
    in_slice_exhausted <= 1'b0;
    in_now_ms          <= '0;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    foreach (level_known[i]) level_known[i] = 0;
    clock_ms   = 0;
    gaps_on    = 1;
    items_sent = 0;
    cfg_writes = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: both idle on empty queues, extremes of ids and levels,
    // duplicate add, demotion, level-zero reload, boost and time wrap.
    schedule(5'd0, 1'b1, 1'b0, 1'b0, 32'd10);
    add_task(5'd0, 1'b1, 2'd0);
    add_task(5'd31, 1'b1, 2'd3);
    add_task(5'd31, 1'b0, 2'd0);
    add_task(5'd7, 1'b1, 2'd1);
    add_task(5'd12, 1'b1, 2'd2);
    schedule(5'd0, 1'b1, 1'b0, 1'b0, 32'd20);
    schedule(5'd31, 1'b0, 1'b1, 1'b1, 32'd30);
    schedule(5'd31, 1'b0, 1'b1, 1'b0, 32'd40);
    schedule(5'd0, 1'b0, 1'b1, 1'b0, 32'd50);
    add_task(5'd21, 1'b1, 2'd0);
    schedule(5'd12, 1'b0, 1'b1, 1'b1, 32'd2000);
    schedule(5'd7, 1'b0, 1'b0, 1'b1, 32'd2100);
    schedule(5'd21, 1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF);
    schedule(5'd31, 1'b0, 1'b1, 1'b1, 32'd5);
    schedule(5'd0, 1'b1, 1'b0, 1'b0, 32'd6);
    schedule(5'd0, 1'b1, 1'b0, 1'b0, 32'd7);
    schedule(5'd0, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
    clock_ms = 32'd3000;

    random_items(250);
    write_interval(20'd1);
    random_items(200);
    write_interval(20'd0);
    random_items(200);
    write_interval(20'hFFFFF);
    random_items(200);
    write_interval(20'd1000000);
    random_items(100);
    write_interval(20'($urandom_range(1, 4000)));
    random_items(100);
    gaps_on = 0;
    random_items(80);

    start <= 1'b0;
    @(posedge clk);
    while (sched_sb.decisions_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sched_sb.decisions_due.size() != 0) sched_sb.errors++;
    $display("%0d commands, %0d schedule results checked, %0d boosts, %0d interval writes",
             items_sent, sched_sb.checked, sched_sb.boosts, cfg_writes);
    $display("%0d mismatches", sched_sb.errors);
    if (sched_sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
